>>> rtl/bsmg_pkg.sv
// ----------------------------------------------------------------------------
// bsmg_pkg
// Shared sizes, types and state codes of the bounded sorted set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bsmg_pkg;

  localparam int N_ENTRIES = 64;
  localparam int CNT_W     = $clog2(N_ENTRIES + 1);
  localparam int VAL_W     = 32;
  localparam int CAP_W     = 7;
  localparam int REP_W     = 7;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                    shift_en;
    logic signed [VAL_W-1:0] v;
  } chain_ctrl_t;

  typedef struct packed {
    logic                    lo_hit;
    logic                    hi_hit;
    logic        [VAL_W-1:0] lo_gap;
    logic        [VAL_W-1:0] hi_gap;
    logic signed [VAL_W-1:0] head;
  } chain_stat_t;

endpackage

`default_nettype wire

>>> rtl/bounded_set_min_max_gap_top.sv
// ----------------------------------------------------------------------------
// bounded_set_min_max_gap_top
// Bounded sorted multiset of signed values reporting count, minimum
// neighbor gap and full span after every offered item.
// ----------------------------------------------------------------------------
// A stored item passes through a compare state and a shift state for each
// copy and then the done state; a rejected item or one with a zero repeat
// goes straight to the done state. Copies go into the row of cells one at a
// time: each copy is compared against all cells and the gap candidates are
// merged, then the row shifts and folds the gap into the running minimum.
// The next input transfer is taken as soon as the result is in the output
// register. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module bounded_set_min_max_gap_top (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic signed [bsmg_pkg::VAL_W-1:0]   value,
  input  wire logic        [bsmg_pkg::REP_W-1:0]   repeat_req,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     accepted,
  output logic             [bsmg_pkg::CNT_W-1:0]   stored_count,
  output logic                                     span_valid,
  output logic             [bsmg_pkg::VAL_W-1:0]   shortest_span,
  output logic             [bsmg_pkg::VAL_W-1:0]   longest_span,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic        [bsmg_pkg::ADDR_W-1:0]  paddr,
  input  wire logic        [bsmg_pkg::DATA_W-1:0]  pwdata,
  output logic             [bsmg_pkg::DATA_W-1:0]  prdata,
  output logic                                     pready
);

  bsmg_pkg::state_t      state, state_next;
  bsmg_pkg::chain_ctrl_t ctrl;
  bsmg_pkg::chain_stat_t stat;

  logic [bsmg_pkg::CAP_W-1:0]        capacity;
  logic [bsmg_pkg::CNT_W-1:0]        held_count;
  logic [bsmg_pkg::VAL_W-1:0]        min_gap;
  logic [bsmg_pkg::VAL_W-1:0]        min_gap_next;
  logic signed [bsmg_pkg::VAL_W-1:0] v_reg;
  logic signed [bsmg_pkg::VAL_W-1:0] max_val;
  logic [bsmg_pkg::REP_W-1:0]        copies_left;
  logic                              acc_reg;
  logic                              lo_hit, hi_hit;
  logic [bsmg_pkg::VAL_W-1:0]        lo_gap, hi_gap;

  logic                              take_in;
  logic                              cmp_en;
  logic                              shift_en;
  logic                              out_load;
  logic [bsmg_pkg::CNT_W:0]          cap_sat;
  logic [bsmg_pkg::CNT_W:0]          room;
  logic                              fits;
  logic signed [bsmg_pkg::VAL_W:0]   span;
  logic                              cfg_wr;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? bsmg_pkg::DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= bsmg_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      capacity <= pwdata[bsmg_pkg::CAP_W-1:0];
    end
  end

  // room check
  always_comb begin
    if ((bsmg_pkg::CNT_W + 1)'(capacity) > (bsmg_pkg::CNT_W + 1)'(bsmg_pkg::N_ENTRIES)) begin
      cap_sat = (bsmg_pkg::CNT_W + 1)'(bsmg_pkg::N_ENTRIES);
    end else begin
      cap_sat = (bsmg_pkg::CNT_W + 1)'(capacity);
    end
    if ((bsmg_pkg::CNT_W + 1)'(held_count) < cap_sat) begin
      room = cap_sat - (bsmg_pkg::CNT_W + 1)'(held_count);
    end else begin
      room = '0;
    end
    fits = (bsmg_pkg::CNT_W + 1)'(repeat_req) <= room;
  end

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      bsmg_pkg::S_IDLE: begin
        if (in_valid) begin
          if (fits && (repeat_req != '0)) begin
            state_next = bsmg_pkg::S_CMP;
          end else begin
            state_next = bsmg_pkg::S_DONE;
          end
        end
      end
      bsmg_pkg::S_CMP: begin
        state_next = bsmg_pkg::S_SHIFT;
      end
      bsmg_pkg::S_SHIFT: begin
        if (copies_left == bsmg_pkg::REP_W'(1)) begin
          state_next = bsmg_pkg::S_DONE;
        end else begin
          state_next = bsmg_pkg::S_CMP;
        end
      end
      bsmg_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = bsmg_pkg::S_IDLE;
        end
      end
      default: state_next = bsmg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmp_en   = 1'b0;
    shift_en = 1'b0;
    out_load = 1'b0;
    unique case (state)
      bsmg_pkg::S_IDLE:  in_ready = 1'b1;
      bsmg_pkg::S_CMP:   cmp_en   = 1'b1;
      bsmg_pkg::S_SHIFT: shift_en = 1'b1;
      bsmg_pkg::S_DONE:  out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign take_in = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bsmg_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    if (take_in) begin
      v_reg       <= value;
      copies_left <= repeat_req;
      acc_reg     <= fits;
    end else if (shift_en) begin
      copies_left <= copies_left - bsmg_pkg::REP_W'(1);
    end
  end

  // cell row
  assign ctrl.shift_en = shift_en;
  assign ctrl.v        = v_reg;

  bsmg_chain u_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .count (held_count),
    .stat  (stat)
  );

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      lo_hit <= stat.lo_hit;
      hi_hit <= stat.hi_hit;
      lo_gap <= stat.lo_gap;
      hi_gap <= stat.hi_gap;
    end
  end

  always_comb begin
    min_gap_next = min_gap;
    if (lo_hit && (lo_gap < min_gap_next)) begin
      min_gap_next = lo_gap;
    end
    if (hi_hit && (hi_gap < min_gap_next)) begin
      min_gap_next = hi_gap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
      min_gap    <= '1;
    end else if (shift_en) begin
      held_count <= held_count + bsmg_pkg::CNT_W'(1);
      min_gap    <= min_gap_next;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en && ((held_count == '0) || (v_reg > max_val))) begin
      max_val <= v_reg;
    end
  end

  // result register
  assign span = {max_val[bsmg_pkg::VAL_W-1], max_val} - {stat.head[bsmg_pkg::VAL_W-1], stat.head};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      accepted     <= acc_reg;
      stored_count <= held_count;
      if (held_count >= bsmg_pkg::CNT_W'(2)) begin
        span_valid    <= 1'b1;
        shortest_span <= min_gap;
        longest_span  <= span[bsmg_pkg::VAL_W-1:0];
      end else begin
        span_valid    <= 1'b0;
        shortest_span <= '0;
        longest_span  <= '0;
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= bsmg_pkg::CNT_W'(bsmg_pkg::N_ENTRIES))
    else $error("held count above store size");

  a_shift_count: assert property (@(posedge clk) disable iff (rst)
    shift_en |=> held_count == $past(held_count) + bsmg_pkg::CNT_W'(1))
    else $error("shift did not add one value");

  a_gap_monotone: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> min_gap <= $past(min_gap))
    else $error("minimum gap grew");

  a_span_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> span_valid == (stored_count >= bsmg_pkg::CNT_W'(2)))
    else $error("span flag disagrees with stored count");
`endif

endmodule

`default_nettype wire

>>> rtl/bsmg_cell.sv
// ----------------------------------------------------------------------------
// bsmg_cell
// One slot of the sorted row: compares against the offered value v, takes the
// left neighbor's value or v on a shift and reports its gap to v.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsmg_cell (
  input  wire logic                                clk,
  input  wire logic                                shift_en,
  input  wire logic signed [bsmg_pkg::VAL_W-1:0]   v,
  input  wire logic                                occ,
  input  wire logic                                left_ins,
  input  wire logic signed [bsmg_pkg::VAL_W-1:0]   left_val,
  input  wire logic                                right_ins,
  output logic signed      [bsmg_pkg::VAL_W-1:0]   val,
  output logic                                     ins,
  output logic                                     lo_hit,
  output logic             [bsmg_pkg::VAL_W-1:0]   lo_gap,
  output logic                                     hi_hit,
  output logic             [bsmg_pkg::VAL_W-1:0]   hi_gap
);

  logic signed [bsmg_pkg::VAL_W:0] diff;

  assign ins  = !occ || (val > v);
  assign diff = {v[bsmg_pkg::VAL_W-1], v} - {val[bsmg_pkg::VAL_W-1], val};

  // last held value not above v, and first held value above v
  assign lo_hit = occ && !ins && right_ins;
  assign hi_hit = occ && ins && !left_ins;
  assign lo_gap = lo_hit ? diff[bsmg_pkg::VAL_W-1:0] : '0;
  assign hi_gap = hi_hit ? (~diff[bsmg_pkg::VAL_W-1:0] + bsmg_pkg::VAL_W'(1)) : '0;

  always_ff @(posedge clk) begin
    if (shift_en && ins) begin
      val <= left_ins ? left_val : v;
    end
  end

endmodule

`default_nettype wire

>>> rtl/bsmg_chain.sv
// ----------------------------------------------------------------------------
// bsmg_chain
// Row of sorted cells with the gap candidates merged across the row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bsmg_chain (
  input  wire logic                              clk,
  input  wire bsmg_pkg::chain_ctrl_t             ctrl,
  input  wire logic [bsmg_pkg::CNT_W-1:0]        count,
  output bsmg_pkg::chain_stat_t                  stat
);

  localparam int N = bsmg_pkg::N_ENTRIES;

  logic signed [bsmg_pkg::VAL_W-1:0] val    [N];
  logic                              ins    [N];
  logic                              lo_hit [N];
  logic                              hi_hit [N];
  logic        [bsmg_pkg::VAL_W-1:0] lo_gap [N];
  logic        [bsmg_pkg::VAL_W-1:0] hi_gap [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                              occ;
    logic                              left_ins;
    logic signed [bsmg_pkg::VAL_W-1:0] left_val;
    logic                              right_ins;

    assign occ = bsmg_pkg::CNT_W'(i) < count;

    if (i == 0) begin : g_head
      assign left_ins = 1'b0;
      assign left_val = ctrl.v;
    end else begin : g_body
      assign left_ins = ins[i-1];
      assign left_val = val[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign right_ins = 1'b1;
    end else begin : g_mid
      assign right_ins = ins[i+1];
    end

    bsmg_cell u_cell (
      .clk       (clk),
      .shift_en  (ctrl.shift_en),
      .v         (ctrl.v),
      .occ       (occ),
      .left_ins  (left_ins),
      .left_val  (left_val),
      .right_ins (right_ins),
      .val       (val[i]),
      .ins       (ins[i]),
      .lo_hit    (lo_hit[i]),
      .lo_gap    (lo_gap[i]),
      .hi_hit    (hi_hit[i]),
      .hi_gap    (hi_gap[i])
    );
  end

  // at most one cell raises each hit, so the gaps merge by or
  always_comb begin
    stat.lo_hit = 1'b0;
    stat.hi_hit = 1'b0;
    stat.lo_gap = '0;
    stat.hi_gap = '0;
    for (int i = 0; i < N; i++) begin
      stat.lo_hit = stat.lo_hit | lo_hit[i];
      stat.hi_hit = stat.hi_hit | hi_hit[i];
      stat.lo_gap = stat.lo_gap | lo_gap[i];
      stat.hi_gap = stat.hi_gap | hi_gap[i];
    end
    stat.head = val[0];
  end

endmodule

`default_nettype wire
